/* rtl/hierarchical_bitmap_allocator_defines.svh */
// Assertion macros used by the allocator checker.
`ifndef HIERARCHICAL_BITMAP_ALLOCATOR_DEFINES_SVH
`define HIERARCHICAL_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hba_pkg.sv */
// Shared types, widths and codes of the hierarchical bitmap allocator.
`default_nettype none

package hba_pkg;

    localparam int WORD_BITS       = 64;
    localparam int TREE_LEVELS_DEF = 2;
    localparam int OP_W            = 4;
    localparam int IDX_W           = 13;
    localparam int RES_W           = 12;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 13;

    localparam logic [OP_W-1:0] OP_INIT  = 4'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 4'd1;
    localparam logic [OP_W-1:0] OP_AT    = 4'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 4'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 4'd4;
    localparam logic [OP_W-1:0] OP_PEEK  = 4'd5;
    localparam logic [OP_W-1:0] OP_NEXT  = 4'd6;
    localparam logic [OP_W-1:0] OP_COUNT = 4'd7;
    localparam logic [OP_W-1:0] OP_SPAN  = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_FULL = 1'd1;

    localparam logic [IDX_W-1:0] CAPACITY_RESET = 13'd4096;

    typedef logic [WORD_BITS-1:0] word_t;

    // What the word evaluator is asked about the word just read.
    typedef struct packed {
        word_t      word;
        logic [5:0] skip;       // bits below this are ignored / counted
        logic       cnt_full;   // count the whole word
        logic [2:0] span_log;   // log2 of a short span
    } word_query_t;

    typedef struct packed {
        logic       all_ones;
        logic       free_hit;
        logic [5:0] free_pos;
        logic [6:0] ones;
        logic       span_hit;
        logic [5:0] span_pos;
    } word_info_t;

endpackage

`default_nettype wire

/* rtl/hba_ifs.sv */
// Channel interfaces of the allocator: command, response and register write.
`default_nettype none

interface hba_cmd_if import hba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] item_index;
    logic [IDX_W-1:0] span_length;

    modport source (output valid, output operation, output item_index,
                    output span_length, input ready);
    modport sink   (input valid, input operation, input item_index,
                    input span_length, output ready);
endinterface

interface hba_rsp_if import hba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [RES_W-1:0] result_index;
    logic             is_allocated;
    logic [IDX_W-1:0] taken_count;
    logic             error;

    modport source (output valid, output found, output result_index,
                    output is_allocated, output taken_count, output error,
                    input ready);
    modport sink   (input valid, input found, input result_index,
                    input is_allocated, input taken_count, input error,
                    output ready);
endinterface

interface hba_cfg_if import hba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/hba_word_eval.sv */
// Word evaluator: lowest free bit, masked popcount and aligned free-span search.
`default_nettype none

module hba_word_eval import hba_pkg::*; (
    input  word_query_t q,
    output word_info_t  info
);

    word_t            low_mask;
    word_t            masked;
    word_t            inv;
    word_t            low_bit;
    word_t            cnt_word;
    word_t            starts;
    word_t            span_low;
    logic [5:0][63:0] free_tree;
    logic [5:0]       free_pos;
    logic [5:0]       span_pos;

    // ones below skip
    assign low_mask = ~({WORD_BITS{1'b1}} << q.skip);
    assign masked   = q.word | low_mask;
    assign inv      = ~masked;
    assign low_bit  = inv & (~inv + 64'd1);
    assign cnt_word = q.cnt_full ? q.word : (q.word & low_mask);

    // free_tree[l][k]: aligned block k of 2^l bits is all free
    always_comb
    begin
        free_tree    = '0;
        free_tree[0] = ~q.word;
        for (int l = 1; l < 6; l++)
        begin
            for (int k = 0; k < (64 >> l); k++)
            begin
                free_tree[l][k] = free_tree[l-1][2*k] & free_tree[l-1][2*k+1];
            end
        end
    end

    always_comb
    begin
        starts = '0;
        for (int p = 0; p < 64; p++)
        begin
            for (int l = 0; l < 6; l++)
            begin
                if (q.span_log == 3'(l) && (p & ((1 << l) - 1)) == 0)
                begin
                    starts[p] = free_tree[l][p >> l];
                end
            end
        end
    end

    assign span_low = (starts & ~low_mask) & (~(starts & ~low_mask) + 64'd1);

    always_comb
    begin
        free_pos = '0;
        span_pos = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (low_bit[i])
            begin
                free_pos = free_pos | 6'(i);
            end
            if (span_low[i])
            begin
                span_pos = span_pos | 6'(i);
            end
        end
    end

    assign info.all_ones = &q.word;
    assign info.free_hit = |inv;
    assign info.free_pos = free_pos;
    assign info.ones     = 7'($countones(cnt_word));
    assign info.span_hit = |(starts & ~low_mask);
    assign info.span_pos = span_pos;

endmodule

`default_nettype wire

/* rtl/hierarchical_bitmap_allocator.sv */
// Top level of the 64-ary hierarchical bitmap allocator.
`default_nettype none

// Hierarchical bitmap allocator over up to 4096 items. Occupancy lives in one
// 65 x 64-bit synchronous memory: word 0 is the root, words 1..64 the leaves
// when the capacity exceeds 64, else word 0 is the only leaf. A root bit is set
// when its leaf word is full. One command is worked at a time; the next one is
// taken as soon as the previous result sits in the response register, even if
// the response side stalls. Alloc lowest / alloc at / free / query / peek read
// the root, read the leaf, then, for the three that change it, write the leaf
// and, with two levels, the root; the leaf step is skipped when the root shows
// no free leaf. Next free, count below and span search read, then evaluate,
// each leaf word scanned; init sweeps every leaf word, one write per cycle,
// then writes the root with two levels. Errors on range or span size answer
// without touching the memory. Memory content is undefined until the first
// init; there is no clearing pass after reset. Register writes take effect at
// the next init and are accepted at any time (cfg.ready is tied high).
module hierarchical_bitmap_allocator import hba_pkg::*; #(
    parameter int LEVELS = TREE_LEVELS_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    hba_cmd_if.sink   cmd,
    hba_rsp_if.source rsp,
    hba_cfg_if.sink   cfg
);

    localparam int TREE_DEPTH = (LEVELS >= 2) ? 65 : 1;
    localparam int ADDR_W     = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int ITEM_LIMIT = (LEVELS >= 2) ? 4096 : 64;

    localparam logic [1:0] LV_ONE = 2'd1;
    localparam logic [1:0] LV_TWO = 2'd2;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ROOT      = 4'd1;
    localparam logic [3:0] S_LEAF      = 4'd2;
    localparam logic [3:0] S_WROOT     = 4'd3;
    localparam logic [3:0] S_SCAN_RD   = 4'd4;
    localparam logic [3:0] S_SCAN_EV   = 4'd5;
    localparam logic [3:0] S_INIT      = 4'd6;
    localparam logic [3:0] S_INIT_ROOT = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    // occupancy memory
    word_t             tree_mem [TREE_DEPTH];
    word_t             tree_rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;

    // control
    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  capacity_reg, capacity_next;
    logic              start_full_reg, start_full_next;
    logic [IDX_W-1:0]  managed_reg, managed_next;
    logic [1:0]        lv_reg, lv_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // per-command payload
    logic [OP_W-1:0]   op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [6:0]        need_reg, need_next;
    logic              span_short_reg, span_short_next;
    logic [2:0]        span_log_reg, span_log_next;
    logic [7:0]        j_reg, j_next;
    logic [6:0]        run_reg, run_next;
    word_t             root_reg, root_next;
    logic [5:0]        z0_reg, z0_next;
    logic [ADDR_W-1:0] leaf_addr_reg, leaf_addr_next;
    logic              leaf_full_reg, leaf_full_next;

    // pending result
    logic              fnd_reg, fnd_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic              isal_reg, isal_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              err_reg, err_next;

    // response register
    logic              out_found_reg, out_found_next;
    logic [RES_W-1:0]  out_res_reg, out_res_next;
    logic              out_isal_reg, out_isal_next;
    logic [IDX_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_err_reg, out_err_next;

    word_query_t       eq;
    word_info_t        info;

    // helpers
    logic              two_level;
    logic [7:0]        last_j;
    logic [7:0]        idx_hi;
    logic              cmd_xfer;
    logic [IDX_W-1:0]  n_clamped;
    logic [IDX_W-1:0]  len_in;
    logic              len_pow2;
    logic              len_ok;
    logic [13:0]       idx_round;
    logic [7:0]        span_j0;
    logic [2:0]        len_log;
    logic [11:0]       acc;
    word_t             new_leaf;
    logic              leaf_bad;
    word_t             init_word;
    logic [7:0]        managed_hi;
    logic [6:0]        run_inc;
    logic [6:0]        span_start;

    assign two_level  = (lv_reg == LV_TWO);
    assign last_j     = two_level ? 8'd63 : 8'd0;
    assign idx_hi     = {1'b0, idx_reg[12:6]};
    assign cmd_xfer   = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign n_clamped  = (capacity_reg > IDX_W'(ITEM_LIMIT)) ? IDX_W'(ITEM_LIMIT) : capacity_reg;
    assign len_in     = cmd.span_length;
    assign len_pow2   = ((len_in & (len_in - 13'd1)) == '0);
    assign len_ok     = (len_in != '0) && ((len_pow2 && len_in <= 13'd64) || len_in[5:0] == 6'd0);
    assign idx_round  = {1'b0, cmd.item_index} + 14'd63;
    assign span_j0    = (len_in < 13'd64) ? {1'b0, cmd.item_index[12:6]} : idx_round[13:6];
    assign managed_hi = {1'b0, managed_reg[12:6]};
    assign run_inc    = run_reg + 7'd1;
    assign span_start = j_reg[6:0] + 7'd1 - need_reg;

    always_comb
    begin
        len_log = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (len_in[i])
            begin
                len_log = 3'(i);
            end
        end
    end

    // leaf word j as init leaves it: all taken when start-full is set, else padding at or above the capacity is taken
    always_comb
    begin
        if (start_full_reg || managed_hi < j_reg)
        begin
            init_word = '1;
        end
        else if (managed_hi == j_reg)
        begin
            init_word = {WORD_BITS{1'b1}} << managed_reg[5:0];
        end
        else
        begin
            init_word = '0;
        end
    end

    // evaluator always looks at the last memory read
    always_comb
    begin
        eq.word     = tree_rdata_reg;
        eq.span_log = span_log_reg;
        eq.cnt_full = (j_reg < idx_hi);
        eq.skip     = 6'd0;
        if (state_reg == S_SCAN_EV && (op_reg == OP_COUNT || j_reg == idx_hi))
        begin
            eq.skip = idx_reg[5:0];
        end
    end

    hba_word_eval u_eval (
        .q    (eq),
        .info (info)
    );

    assign acc = two_level ? {z0_reg, info.free_pos} : {6'd0, info.free_pos};

    // leaf update for allocate / free
    always_comb
    begin
        new_leaf = tree_rdata_reg;
        leaf_bad = 1'b0;
        case (op_reg)
            OP_ALLOC: new_leaf = tree_rdata_reg | (64'd1 << info.free_pos);
            OP_AT:
            begin
                leaf_bad = tree_rdata_reg[idx_reg[5:0]];
                new_leaf = tree_rdata_reg | (64'd1 << idx_reg[5:0]);
            end
            OP_FREE:
            begin
                leaf_bad = !tree_rdata_reg[idx_reg[5:0]];
                new_leaf = tree_rdata_reg & ~(64'd1 << idx_reg[5:0]);
            end
            default: new_leaf = tree_rdata_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        capacity_next   = capacity_reg;
        start_full_next = start_full_reg;
        managed_next    = managed_reg;
        lv_next         = lv_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        need_next       = need_reg;
        span_short_next = span_short_reg;
        span_log_next   = span_log_reg;
        j_next          = j_reg;
        run_next        = run_reg;
        root_next       = root_reg;
        z0_next         = z0_reg;
        leaf_addr_next  = leaf_addr_reg;
        leaf_full_next  = leaf_full_reg;
        fnd_next        = fnd_reg;
        res_next        = res_reg;
        isal_next       = isal_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        out_found_next  = out_found_reg;
        out_res_next    = out_res_reg;
        out_isal_next   = out_isal_reg;
        out_cnt_next    = out_cnt_reg;
        out_err_next    = out_err_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = init_word;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_CAPACITY:   capacity_next   = cfg.data;
                REG_START_FULL: start_full_next = cfg.data[0];
                default:        capacity_next   = capacity_reg;
            endcase
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // word 0 is read every idle cycle, ready for the root step
                if (cmd_xfer)
                begin
                    op_next         = cmd.operation;
                    idx_next        = cmd.item_index;
                    need_next       = len_in[12:6];
                    span_short_next = (len_in < 13'd64);
                    span_log_next   = len_log;
                    run_next        = '0;
                    fnd_next        = 1'b0;
                    res_next        = '0;
                    isal_next       = 1'b0;
                    cnt_next        = '0;
                    err_next        = 1'b0;
                    case (cmd.operation)
                        OP_INIT:
                        begin
                            managed_next = n_clamped;
                            lv_next      = (LEVELS >= 2 && n_clamped > 13'd64) ? LV_TWO : LV_ONE;
                            j_next       = '0;
                            root_next    = '0;
                            state_next   = S_INIT;
                        end
                        OP_ALLOC, OP_PEEK:
                        begin
                            state_next = S_ROOT;
                        end
                        OP_AT, OP_FREE, OP_QUERY:
                        begin
                            if (cmd.item_index >= managed_reg)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ROOT;
                            end
                        end
                        OP_NEXT:
                        begin
                            j_next = {1'b0, cmd.item_index[12:6]};
                            if (cmd.item_index >= managed_reg)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_COUNT:
                        begin
                            j_next = '0;
                            if (cmd.item_index > managed_reg)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_SPAN:
                        begin
                            j_next = span_j0;
                            if (!len_ok)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else if (span_j0 > last_j)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_ROOT:
            begin
                root_next = tree_rdata_reg;
                if (op_reg == OP_ALLOC || op_reg == OP_PEEK)
                begin
                    z0_next        = info.free_pos;
                    leaf_addr_next = two_level ? ADDR_W'({2'b0, info.free_pos} + 8'd1) : '0;
                end
                else
                begin
                    z0_next        = idx_reg[11:6];
                    leaf_addr_next = two_level ? ADDR_W'({2'b0, idx_reg[11:6]} + 8'd1) : '0;
                end
                rd_addr = leaf_addr_next;
                if ((op_reg == OP_ALLOC || op_reg == OP_PEEK) && info.all_ones)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LEAF;
                end
            end

            S_LEAF:
            begin
                leaf_full_next = &new_leaf;
                state_next     = S_DONE;
                wr_addr        = leaf_addr_reg;
                wr_data        = new_leaf;
                case (op_reg)
                    OP_ALLOC, OP_PEEK:
                    begin
                        if (info.free_hit && {1'b0, acc} < managed_reg)
                        begin
                            fnd_next = 1'b1;
                            res_next = acc;
                            if (op_reg == OP_ALLOC)
                            begin
                                wr_en = 1'b1;
                                if (two_level)
                                begin
                                    state_next = S_WROOT;
                                end
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        isal_next = tree_rdata_reg[idx_reg[5:0]];
                    end
                    OP_AT, OP_FREE:
                    begin
                        if (leaf_bad)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (op_reg == OP_AT)
                            begin
                                fnd_next = 1'b1;
                                res_next = idx_reg[11:0];
                            end
                            if (two_level)
                            begin
                                state_next = S_WROOT;
                            end
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end

            S_WROOT:
            begin
                // root bit of the touched leaf follows its fullness
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = (root_reg & ~(64'd1 << z0_reg))
                           | (word_t'(leaf_full_reg) << z0_reg);
                state_next = S_DONE;
            end

            S_SCAN_RD:
            begin
                rd_addr    = two_level ? ADDR_W'(j_reg + 8'd1) : '0;
                state_next = S_SCAN_EV;
            end

            S_SCAN_EV:
            begin
                state_next = (j_reg < last_j) ? S_SCAN_RD : S_DONE;
                j_next     = j_reg + 8'd1;
                case (op_reg)
                    OP_NEXT:
                    begin
                        if (info.free_hit)
                        begin
                            fnd_next   = 1'b1;
                            res_next   = {j_reg[5:0], info.free_pos};
                            state_next = S_DONE;
                        end
                    end
                    OP_COUNT:
                    begin
                        cnt_next = cnt_reg + IDX_W'(info.ones);
                        if (j_reg >= idx_hi)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    OP_SPAN:
                    begin
                        if (span_short_reg)
                        begin
                            if (info.span_hit)
                            begin
                                fnd_next   = 1'b1;
                                res_next   = {j_reg[5:0], info.span_pos};
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            run_next = (tree_rdata_reg == '0) ? run_inc : 7'd0;
                            if (tree_rdata_reg == '0 && run_inc == need_reg)
                            begin
                                fnd_next   = 1'b1;
                                res_next   = {span_start[5:0], 6'd0};
                                state_next = S_DONE;
                            end
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end

            S_INIT:
            begin
                wr_en                 = 1'b1;
                wr_addr               = two_level ? ADDR_W'(j_reg + 8'd1) : '0;
                wr_data               = init_word;
                root_next[j_reg[5:0]] = &init_word;
                j_next                = j_reg + 8'd1;
                if (j_reg == last_j)
                begin
                    state_next = two_level ? S_INIT_ROOT : S_DONE;
                end
            end

            S_INIT_ROOT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = root_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // wait for the response register to drain
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    out_found_next = fnd_reg;
                    out_res_next   = res_reg;
                    out_isal_next  = isal_reg;
                    out_cnt_next   = cnt_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
        tree_rdata_reg <= tree_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            capacity_reg   <= CAPACITY_RESET;
            start_full_reg <= 1'b0;
            managed_reg    <= 13'd64;
            lv_reg         <= LV_ONE;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            start_full_reg <= start_full_next;
            managed_reg    <= managed_next;
            lv_reg         <= lv_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        need_reg       <= need_next;
        span_short_reg <= span_short_next;
        span_log_reg   <= span_log_next;
        j_reg          <= j_next;
        run_reg        <= run_next;
        root_reg       <= root_next;
        z0_reg         <= z0_next;
        leaf_addr_reg  <= leaf_addr_next;
        leaf_full_reg  <= leaf_full_next;
        fnd_reg        <= fnd_next;
        res_reg        <= res_next;
        isal_reg       <= isal_next;
        cnt_reg        <= cnt_next;
        err_reg        <= err_next;
        out_found_reg  <= out_found_next;
        out_res_reg    <= out_res_next;
        out_isal_reg   <= out_isal_next;
        out_cnt_reg    <= out_cnt_next;
        out_err_reg    <= out_err_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.result_index = out_res_reg;
    assign rsp.is_allocated = out_isal_reg;
    assign rsp.taken_count  = out_cnt_reg;
    assign rsp.error        = out_err_reg;

endmodule

`default_nettype wire

/* rtl/hba_checker.sv */
// Port-level checker of the allocator response channel, bound to the top level.
`default_nettype none

`include "hierarchical_bitmap_allocator_defines.svh"

module hba_checker import hba_pkg::*; (
    input wire             clk,
    input wire             rst_n,
    input wire             rsp_valid,
    input wire             rsp_ready,
    input wire             found,
    input wire [RES_W-1:0] result_index,
    input wire             is_allocated,
    input wire [IDX_W-1:0] taken_count,
    input wire             error
);

    // stalled response holds
    `HBA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result_index) && $stable(found) && $stable(error), "response changed while stalled")

    // an error carries no other answer
    `HBA_ASSERT_IMP(a_err_clean, rsp_valid && error, !found && result_index == '0 && !is_allocated && taken_count == '0, "error response carries data")

    // nothing found means index zero
    `HBA_ASSERT_IMP(a_miss_zero, rsp_valid && !found, result_index == '0, "index set without found")

    // query and count answers never come with a find or an error
    `HBA_ASSERT_IMP(a_excl, rsp_valid && (is_allocated || taken_count != '0), !found && !error, "mixed answer fields")

endmodule

bind hierarchical_bitmap_allocator hba_checker u_hba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .found        (rsp.found),
    .result_index (rsp.result_index),
    .is_allocated (rsp.is_allocated),
    .taken_count  (rsp.taken_count),
    .error        (rsp.error)
);

`default_nettype wire

/* dv/tb_hierarchical_bitmap_allocator.sv */
// Self-checking testbench of the hierarchical bitmap allocator.
`timescale 1ns / 100ps
`default_nettype none

module tb_hierarchical_bitmap_allocator;
    import hba_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles without any transfer
    localparam int MAX_ITEMS   = 4096;

    typedef struct packed {
        logic             found;
        logic [RES_W-1:0] result_index;
        logic             is_allocated;
        logic [IDX_W-1:0] taken_count;
        logic             error;
    } answer_t;

    logic clk;
    logic rst_n;

    hba_cmd_if cmd_if ();
    hba_rsp_if rsp_if ();
    hba_cfg_if cfg_if ();

    hierarchical_bitmap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source),
        .cfg   (cfg_if.sink)
    );

    // Predicted allocator state: leaf words only, the root follows from them.
    logic [WORD_BITS-1:0] leaf_map [64];
    int leaf_cnt;
    int managed;
    int cap_reg;
    int full_reg;

    answer_t answer_q [$];
    int      held_q [$];     // indices handed out, candidates for free
    int      fail_cnt;
    int      answer_cnt;
    int      item_cnt;
    int      src_idle;       // percent of cycles the sender idles
    int      rsp_stall;      // percent of cycles the receiver stalls
    int      hold_cycles;    // long receiver hold-off, counted down below
    int      quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic taken(int i);
        return leaf_map[i >> 6][i & 63];
    endfunction

    // Latch capacity and rebuild every leaf word; padding is always taken.
    function automatic void apply_init();
        int n;
        n = (cap_reg > MAX_ITEMS) ? MAX_ITEMS : cap_reg;
        managed  = n;
        leaf_cnt = (n > WORD_BITS) ? 64 : 1;
        for (int i = 0; i < 64 * WORD_BITS; i++)
            leaf_map[i >> 6][i & 63] = (i >= n) || (full_reg != 0);
    endfunction

    function automatic answer_t predict_answer(logic [OP_W-1:0] op, int idx, int len);
        answer_t a;
        int      lim;
        int      run;
        logic    clear;
        a   = '0;
        lim = leaf_cnt * WORD_BITS;
        case (op)
            OP_INIT: apply_init();
            OP_ALLOC, OP_PEEK:
                for (int i = 0; i < lim; i++)
                    if (!taken(i))
                    begin
                        a.found        = 1'b1;
                        a.result_index = i[RES_W-1:0];
                        if (op == OP_ALLOC)
                        begin
                            leaf_map[i >> 6][i & 63] = 1'b1;
                            held_q.push_back(i);
                        end
                        break;
                    end
            OP_AT, OP_FREE, OP_QUERY:
                if (idx >= managed)
                    a.error = 1'b1;
                else if (op == OP_QUERY)
                    a.is_allocated = taken(idx);
                else if (op == OP_AT)
                begin
                    if (taken(idx))
                        a.error = 1'b1;
                    else
                    begin
                        leaf_map[idx >> 6][idx & 63] = 1'b1;
                        a.found        = 1'b1;
                        a.result_index = idx[RES_W-1:0];
                        held_q.push_back(idx);
                    end
                end
                else if (!taken(idx))
                    a.error = 1'b1;
                else
                    leaf_map[idx >> 6][idx & 63] = 1'b0;
            OP_NEXT:
                if (idx >= managed)
                    a.error = 1'b1;
                else
                    for (int i = idx; i < lim; i++)
                        if (!taken(i))
                        begin
                            a.found        = 1'b1;
                            a.result_index = i[RES_W-1:0];
                            break;
                        end
            OP_COUNT:
                if (idx > managed)
                    a.error = 1'b1;
                else
                    for (int i = 0; i < idx; i++)
                        a.taken_count += IDX_W'(taken(i));
            OP_SPAN:
                if (len == 0 || !((((len & (len - 1)) == 0) && len <= 64) || len % 64 == 0))
                    a.error = 1'b1;
                else if (len < 64)
                begin
                    // aligned slots inside one leaf word, at or after the start
                    for (int at = ((idx + len - 1) / len) * len; at + len <= lim; at += len)
                    begin
                        clear = 1'b1;
                        for (int b = 0; b < len; b++)
                            if (taken(at + b))
                                clear = 1'b0;
                        if (clear)
                        begin
                            a.found        = 1'b1;
                            a.result_index = at[RES_W-1:0];
                            break;
                        end
                    end
                end
                else
                begin
                    // runs of empty leaf words starting on a word boundary
                    run = 0;
                    for (int j = (idx + 63) / 64; j < leaf_cnt; j++)
                    begin
                        run = (leaf_map[j] == '0) ? run + 1 : 0;
                        if (run == len / 64)
                        begin
                            a.found        = 1'b1;
                            a.result_index = RES_W'((j + 1 - run) * 64);
                            break;
                        end
                    end
                end
            default: a.error = 1'b1;
        endcase
        return a;
    endfunction

    // One command transfer; valid stays high into the next call unless idling.
    task automatic send_op(logic [OP_W-1:0] op, int idx, int len);
        if ($urandom_range(99) < src_idle)
        begin
            cmd_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.operation   <= op;
        cmd_if.item_index  <= idx[IDX_W-1:0];
        cmd_if.span_length <= len[IDX_W-1:0];
        do @(posedge clk); while (!cmd_if.ready);
        answer_q.push_back(predict_answer(op, idx, len));
        item_cnt++;
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only once every outstanding answer has come back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, int data);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (index == REG_CAPACITY)
            cap_reg = data;
        else
            full_reg = data & 1;
    endtask

    task automatic setup(int cap, int full);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_START_FULL, full);
        send_op(OP_INIT, 0, 1);
    endtask

    function automatic int pick_index();
        if (managed > 0 && $urandom_range(9) < 8)
            return $urandom_range(managed - 1);
        return $urandom_range(MAX_ITEMS);
    endfunction

    function automatic int pick_span();
        case ($urandom_range(9))
            0, 1, 2, 3: return 1 << $urandom_range(6);
            4, 5, 6:    return 64 * $urandom_range(1, 4);
            7:          return 64 * $urandom_range(1, 64);
            default:    return $urandom_range(MAX_ITEMS);
        endcase
    endfunction

    // Mostly well-formed alloc / free traffic with random lookups mixed in.
    task automatic random_ops(int count);
        int roll;
        int idx;
        int sel;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            idx  = pick_index();
            if (roll < 2)
                send_op(OP_INIT, idx, 1);
            else if (roll < 24)
                send_op(OP_ALLOC, idx, 1);
            else if (roll < 38)
                send_op(OP_AT, idx, 1);
            else if (roll < 56)
            begin
                if (held_q.size() != 0 && $urandom_range(9) < 8)
                begin
                    sel = $urandom_range(held_q.size() - 1);
                    idx = held_q[sel];
                    held_q.delete(sel);
                end
                send_op(OP_FREE, idx, 1);
            end
            else if (roll < 64)
                send_op(OP_QUERY, idx, 1);
            else if (roll < 70)
                send_op(OP_PEEK, idx, 1);
            else if (roll < 80)
                send_op(OP_NEXT, idx, 1);
            else if (roll < 88)
                send_op(OP_COUNT, $urandom_range(managed), 1);
            else if (roll < 98)
                send_op(OP_SPAN, $urandom_range(9) < 6 ? 0 : idx, pick_span());
            else
                send_op(OP_W'($urandom_range(9, 15)), idx, $urandom_range(MAX_ITEMS));
        end
    endtask

    // Extremes of every field, each operation and the misuse cases.
    task automatic test_directed();
        setup(4096, 0);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_ALLOC, 4096, 4096);
        send_op(OP_AT, 4095, 1);
        send_op(OP_AT, 4095, 1);            // double allocate
        send_op(OP_QUERY, 4095, 1);
        send_op(OP_FREE, 4095, 1);
        send_op(OP_FREE, 4095, 1);          // double free
        send_op(OP_QUERY, 4096, 1);         // out of range
        send_op(OP_PEEK, 0, 1);
        send_op(OP_NEXT, 0, 1);
        send_op(OP_NEXT, 4096, 1);          // out of range
        send_op(OP_COUNT, 4096, 1);
        send_op(OP_SPAN, 0, 1);
        send_op(OP_SPAN, 1, 64);
        send_op(OP_SPAN, 0, 4096);
        send_op(OP_SPAN, 4095, 2);          // nothing at or after the start
        send_op(OP_SPAN, 0, 3);             // bad size
        send_op(OP_SPAN, 0, 0);             // bad size
        send_op(OP_SPAN, 0, 8191);          // bad size, all length bits set
        send_op(OP_SPAN, 8191, 128);
        send_op(4'd9, 8191, 1);             // unknown operation
        send_op(4'd15, 0, 1);
    endtask

    // Capacity and start value extremes: tiny, empty, full, clamped, one row.
    task automatic test_config_extremes();
        setup(1, 1);
        send_op(OP_ALLOC, 0, 1);            // allocator full
        send_op(OP_PEEK, 0, 1);
        send_op(OP_FREE, 0, 1);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_NEXT, 0, 1);
        send_op(OP_COUNT, 1, 1);
        send_op(OP_COUNT, 2, 1);
        setup(0, 0);                        // every item is padding
        send_op(OP_AT, 0, 1);
        send_op(OP_QUERY, 0, 1);
        send_op(OP_COUNT, 0, 1);
        send_op(OP_ALLOC, 0, 1);
        setup(8191, 1);                     // clamped to the tree size
        send_op(OP_FREE, 4095, 1);
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_NEXT, 4000, 1);
        setup(64, 0);
        send_op(OP_SPAN, 0, 64);
        send_op(OP_SPAN, 0, 128);
        setup(65, 0);
        send_op(OP_SPAN, 1, 64);            // partial last word counts as taken
        send_op(OP_COUNT, 65, 1);
    endtask

    task automatic test_random_phases();
        int modes [4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{11, 11}};
        int caps  [5]    = '{4096, 100, 64, 200, 0};
        for (int m = 0; m < 4; m++)
        begin
            src_idle  = modes[m][0];
            rsp_stall = modes[m][1];
            for (int c = 0; c < 5; c++)
            begin
                setup(c == 4 ? $urandom_range(1, 4096) : caps[c], $urandom_range(1));
                random_ops(c == 0 ? 80 : 45);
            end
        end
        src_idle  = 0;
        rsp_stall = 0;
    endtask

    // Receiver holds off while commands keep coming, so the input stalls.
    task automatic test_backpressure();
        setup(300, 0);
        hold_cycles = 400;
        random_ops(40);
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    // Response checking, receiver stalls and the watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                answer_cnt++;
                if (answer_q.size() == 0)
                begin
                    $display("%0t: answer with nothing expected", $time);
                    fail_cnt++;
                end
                else
                begin : compare
                    answer_t e;
                    e = answer_q.pop_front();
                    check_field("found", 32'(e.found), 32'(rsp_if.found));
                    check_field("result_index", 32'(e.result_index),
                                32'(rsp_if.result_index));
                    check_field("is_allocated", 32'(e.is_allocated),
                                32'(rsp_if.is_allocated));
                    check_field("taken_count", 32'(e.taken_count),
                                32'(rsp_if.taken_count));
                    check_field("error", 32'(e.error), 32'(rsp_if.error));
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall);
            if ((rsp_if.valid && rsp_if.ready) || (cmd_if.valid && cmd_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("tb_hierarchical_bitmap_allocator failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.operation   <= OP_INIT;
        cmd_if.item_index  <= '0;
        cmd_if.span_length <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= REG_CAPACITY;
        cfg_if.data        <= '0;
        fail_cnt    = 0;
        answer_cnt  = 0;
        item_cnt    = 0;
        src_idle    = 0;
        rsp_stall   = 0;
        hold_cycles = 0;
        cap_reg     = CAPACITY_RESET;
        full_reg    = 0;
        managed     = 64;
        leaf_cnt    = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (150) @(posedge clk);
        $display("Ran %0d commands, %0d answers checked, over capacities 0 to 8191,",
                 item_cnt, answer_cnt);
        $display("four idle/stall mixes and one long receiver hold-off.");
        if (fail_cnt == 0 && answer_q.size() == 0)
            $display("tb_hierarchical_bitmap_allocator passed");
        else
            $display("tb_hierarchical_bitmap_allocator failed");
        $finish;
    end

endmodule

`default_nettype wire
